[rtl/core/fhc_pkg.sv]
// Shared types and constants for the frame hunt checksum receiver.
`default_nettype none

package fhc_pkg;

   // Frame format markers and limits
   localparam logic [7:0] HEAD_MARK   = 8'h68;
   localparam logic [7:0] END_MARK    = 8'h16;
   localparam int         MIN_HUNT    = 6;
   localparam int         MIN_LEN     = 4;
   localparam int         SUM_START   = 3;
   localparam int         LEN_W       = 16;
   localparam int         FRAME_LEN_W = 9;

   // Transaction opcodes
   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   // Memory access enables
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // One result transaction
   typedef struct packed {
      logic                   frame_ready;
      logic [FRAME_LEN_W-1:0] frame_length;
      logic [7:0]             read_data;
   } result_type;

   // Check sequencer states
   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_RMOD   = 13'b0000000000010,
      S_RWAIT  = 13'b0000000000100,
      S_HUNT   = 13'b0000000001000,
      S_MARK   = 13'b0000000010000,
      S_LEN_LO = 13'b0000000100000,
      S_LEN_HI = 13'b0000001000000,
      S_TAIL   = 13'b0000010000000,
      S_SUM    = 13'b0000100000000,
      S_ACC    = 13'b0001000000000,
      S_CSUM   = 13'b0010000000000,
      S_EMIT   = 13'b0100000000000,
      S_SPARE  = 13'b1000000000000
   } state_type;

endpackage

`default_nettype wire

[rtl/core/fhc_window_mem.sv]
// Window byte store: one write port and one registered read port.
`default_nettype none

module fhc_window_mem
   import fhc_pkg::*;
#(
   parameter int BUF_DEPTH = 256,
   localparam int ADDR_W   = $clog2(BUF_DEPTH)
) (
   input  wire logic              clock,
   input  wire mem_ctl_type       mem_ctl,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] store_ff [BUF_DEPTH];
   logic [7:0] rd_data_ff;

   // Write the pushed byte
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/fhc_check_seq.sv]
// Sequencer: window pointers, frame check walk and read offset reduction.
`default_nettype none

module fhc_check_seq
   import fhc_pkg::*;
#(
   parameter int BUF_DEPTH = 256,
   localparam int ADDR_W   = $clog2(BUF_DEPTH),
   localparam int CNT_W    = ADDR_W + 1,
   localparam int OFF_W    = ((ADDR_W > 8) ? ADDR_W : 8) + 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              opcode,
   input  wire logic [7:0]        rx_byte,
   input  wire logic [7:0]        read_index,
   input  wire logic              out_free,
   output logic                   busy,
   output logic                   done,
   output result_type             result,
   output mem_ctl_type            mem_ctl,
   output logic      [ADDR_W-1:0] wr_addr,
   output logic      [7:0]        wr_data,
   output logic      [ADDR_W-1:0] rd_addr,
   input  wire logic [7:0]        rd_data
);

   state_type        state_ff, state_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        lo_ff, lo_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   result_type        res_ff, res_in;

   logic [ADDR_W-1:0] offset;
   logic [CNT_W-1:0]  addr_sum;
   logic [ADDR_W-1:0] addr;
   logic [ADDR_W-1:0] head_next;
   logic [LEN_W-1:0]  len_field;
   logic [LEN_W-1:0]  len_wide;

   // Window address: head plus offset, wrapped once at the depth
   always_comb begin
      addr_sum = CNT_W'(head_ff) + CNT_W'(offset);
      if (addr_sum >= CNT_W'(BUF_DEPTH)) begin
         addr_sum = addr_sum - CNT_W'(BUF_DEPTH);
      end
      addr = addr_sum[ADDR_W-1:0];
   end

   assign head_next = (head_ff == ADDR_W'(BUF_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign len_field = {rd_data, lo_ff};
   assign len_wide  = LEN_W'(len_ff);

   assign wr_addr = addr;
   assign wr_data = rx_byte;
   assign rd_addr = addr;
   assign busy    = (state_ff != S_IDLE);
   assign done    = (state_ff == S_EMIT) && out_free;
   assign result  = res_ff;

   // Step the check walk
   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      fill_in  = fill_ff;
      len_in   = len_ff;
      k_in     = k_ff;
      sum_in   = sum_ff;
      lo_in    = lo_ff;
      off_in   = off_ff;
      res_in   = res_ff;
      offset   = '0;
      mem_ctl  = '0;

      unique case (state_ff)
         S_IDLE: begin
            offset = fill_ff[ADDR_W-1:0];
            if (start) begin
               res_in = '0;
               if (opcode == OP_READ) begin
                  off_in   = OFF_W'(read_index);
                  state_in = S_RMOD;
               end else begin
                  // Append the byte unless the window is full
                  if (fill_ff < CNT_W'(BUF_DEPTH)) begin
                     mem_ctl.wr_en = 1'b1;
                     fill_in       = fill_ff + 1'b1;
                  end
                  state_in = S_HUNT;
               end
            end
         end
         S_RMOD: begin
            // Reduce the read offset below the depth, then read
            offset = off_ff[ADDR_W-1:0];
            if (off_ff >= OFF_W'(BUF_DEPTH)) begin
               off_in = off_ff - OFF_W'(BUF_DEPTH);
            end else begin
               mem_ctl.rd_en = 1'b1;
               state_in      = S_RWAIT;
            end
         end
         S_RWAIT: begin
            res_in.read_data = rd_data;
            state_in         = S_EMIT;
         end
         S_HUNT: begin
            offset = '0;
            if (fill_ff < CNT_W'(MIN_HUNT)) begin
               state_in = S_EMIT;
            end else begin
               mem_ctl.rd_en = 1'b1;
               state_in      = S_MARK;
            end
         end
         S_MARK: begin
            offset = ADDR_W'(1);
            if (rd_data != HEAD_MARK) begin
               if (fill_ff > CNT_W'(MIN_HUNT)) begin
                  head_in  = head_next;
                  fill_in  = fill_ff - 1'b1;
                  state_in = S_HUNT;
               end else begin
                  state_in = S_EMIT;
               end
            end else begin
               mem_ctl.rd_en = 1'b1;
               state_in      = S_LEN_LO;
            end
         end
         S_LEN_LO: begin
            offset        = ADDR_W'(2);
            lo_in         = rd_data;
            mem_ctl.rd_en = 1'b1;
            state_in      = S_LEN_HI;
         end
         S_LEN_HI: begin
            offset = ADDR_W'(len_field - 1'b1);
            if ((len_field < LEN_W'(MIN_LEN)) || (len_field > LEN_W'(BUF_DEPTH))) begin
               head_in  = head_next;
               fill_in  = fill_ff - 1'b1;
               state_in = S_HUNT;
            end else if (LEN_W'(fill_ff) < len_field) begin
               state_in = S_EMIT;
            end else begin
               len_in        = CNT_W'(len_field);
               mem_ctl.rd_en = 1'b1;
               state_in      = S_TAIL;
            end
         end
         S_TAIL: begin
            if (rd_data != END_MARK) begin
               head_in  = head_next;
               fill_in  = fill_ff - 1'b1;
               state_in = S_HUNT;
            end else begin
               sum_in   = '0;
               k_in     = CNT_W'(SUM_START);
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            // Read the next covered byte, or the checksum byte at the end
            mem_ctl.rd_en = 1'b1;
            if (CNT_W'(k_ff + 2'd2) < len_ff) begin
               offset   = k_ff[ADDR_W-1:0];
               state_in = S_ACC;
            end else begin
               offset   = ADDR_W'(len_ff - 2'd2);
               state_in = S_CSUM;
            end
         end
         S_ACC: begin
            sum_in   = sum_ff + rd_data;
            k_in     = k_ff + 1'b1;
            state_in = S_SUM;
         end
         S_CSUM: begin
            if (rd_data != sum_ff) begin
               head_in  = head_next;
               fill_in  = fill_ff - 1'b1;
               state_in = S_HUNT;
            end else begin
               // Accept the frame and empty the window
               fill_in             = '0;
               res_in.frame_ready  = 1'b1;
               res_in.frame_length = len_wide[FRAME_LEN_W-1:0];
               state_in            = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      len_ff <= len_in;
      k_ff   <= k_in;
      sum_ff <= sum_in;
      lo_ff  <= lo_in;
      off_ff <= off_in;
      res_ff <= res_in;
   end

endmodule

`default_nettype wire

[rtl/core/frame_hunt_checksum_receiver.sv]
// Top level of the frame hunt checksum receiver: handshake, result register, sequencer, store.
//
// Each push transaction appends a byte to a circular window of BUF_DEPTH bytes and then
// hunts for a frame: 0x68 at the window start, a little-endian length in bytes 1..2
// (4..BUF_DEPTH), 0x16 as the last byte and the mod-256 sum of bytes 3..len-3 in byte len-2.
// A failed test drops the oldest byte and the hunt restarts, but a header test that fails
// with only MIN_HUNT bytes left ends the push; an accepted frame reports its length and
// empties the window, and read transactions then return its bytes. One item is worked on at
// a time, all through the single read port of the window memory (one byte per access,
// registered read data): the hunt reads the header, the length, the end mark, then each
// summed byte and the checksum byte in turn. A read first steps read_index down by BUF_DEPTH
// while it is BUF_DEPTH or beyond. The next request can be accepted in the cycle the result
// shows. A result waiting in the output register does not block the next request from
// being accepted.
`default_nettype none

module frame_hunt_checksum_receiver
   import fhc_pkg::*;
#(
   parameter int BUF_DEPTH = 256,
   localparam int ADDR_W   = $clog2(BUF_DEPTH)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_opcode,
   input  wire logic [7:0]             req_rx_byte,
   input  wire logic [7:0]             req_read_index,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_frame_ready,
   output logic      [FRAME_LEN_W-1:0] rsp_frame_length,
   output logic      [7:0]             rsp_read_data
);

   logic              busy;
   logic              done;
   logic              out_free;
   result_type        result;
   mem_ctl_type       mem_ctl;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;

   // Hold off requests while a transaction is being worked on
   assign req_stall = busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   fhc_check_seq #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (req_valid && !busy),
      .opcode     (req_opcode),
      .rx_byte    (req_rx_byte),
      .read_index (req_read_index),
      .out_free   (out_free),
      .busy       (busy),
      .done       (done),
      .result     (result),
      .mem_ctl    (mem_ctl),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   fhc_window_mem #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register: load a finished result, hold while stalled
   assign rsp_valid_in = done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_ready  = rsp_data_ff.frame_ready;
   assign rsp_frame_length = rsp_data_ff.frame_length;
   assign rsp_read_data    = rsp_data_ff.read_data;

endmodule

`default_nettype wire
